>>> sv/rim_pkg.sv
package rim_pkg;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_STAGES  = DIV_STEPS + 2;
  localparam int MID_STAGES  = 7;
  localparam int PIPE_DEPTH  = 2 + SQRT_STAGES + MID_STAGES + DIV_STAGES;

  typedef enum logic [1:0] {
    CFG_INNER_RADIUS = 2'd0,
    CFG_COEF_A       = 2'd1,
    CFG_COEF_B       = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

>>> sv/rim_sqrt.sv
module rim_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [33:0] rem  [rim_pkg::SQRT_STAGES];
  logic [31:0] q    [rim_pkg::SQRT_STAGES];
  logic [63:0] rest [rim_pkg::SQRT_STAGES-1];

  for (genvar k = 0; k < rim_pkg::SQRT_STAGES; k++) begin : g_step
    logic [33:0] rem_i;
    logic [33:0] r2;
    logic [33:0] trial;
    logic [31:0] q_i;
    logic [63:0] rest_i;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign q_i    = '0;
      assign rest_i = radicand;
    end else begin : g_next
      assign rem_i  = rem[k-1];
      assign q_i    = q[k-1];
      assign rest_i = rest[k-1];
    end

    assign r2    = {rem_i[31:0], rest_i[63:62]};
    assign trial = {q_i, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? (r2 - trial) : r2;
        q[k]   <= {q_i[30:0], ge};
      end
    end

    if (k < rim_pkg::SQRT_STAGES - 1) begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          rest[k] <= {rest_i[61:0], 2'b00};
        end
      end
    end
  end

  assign root = q[rim_pkg::SQRT_STAGES-1];

endmodule

>>> sv/rim_div.sv
module rim_div (
  input  logic        clk,
  input  logic        en,
  input  logic [95:0] divisor,
  input  logic [31:0] coord,
  input  logic        dneg,
  output logic [31:0] result,
  output logic        ovf
);

  typedef struct packed {
    logic big;
    logic mzero;
    logic czero;
    logic neg;
    logic cneg;
  } flag_t;

  localparam int N = rim_pkg::DIV_STEPS;

  logic [95:0] m   [N];
  logic [95:0] rem [N+1];
  logic [31:0] q   [N];
  flag_t       fl  [N+1];

  logic [31:0] cmag;
  logic [47:0] num;

  assign cmag = rim_pkg::mag32(coord);
  assign num  = {cmag, 16'h0000};

  always_ff @(posedge clk) begin
    if (en) begin
      m[0]        <= divisor;
      rem[0]      <= {48'h0, num};
      fl[0].big   <= ({48'h0, num} >= divisor);
      fl[0].mzero <= (divisor == 96'h0);
      fl[0].czero <= (cmag == 32'h0);
      fl[0].neg   <= coord[31] ^ dneg;
      fl[0].cneg  <= coord[31];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [96:0] r2;
    logic [96:0] diff;
    logic [31:0] q_i;
    logic        ge;

    if (k == 0) begin : g_first
      assign q_i = '0;
    end else begin : g_next
      assign q_i = q[k-1];
    end

    assign r2   = {rem[k], 1'b0};
    assign diff = r2 - {1'b0, m[k]};
    assign ge   = (r2 >= {1'b0, m[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[95:0] : r2[95:0];
        q[k]     <= {q_i[30:0], ge};
        fl[k+1]  <= fl[k];
      end
    end

    if (k < N - 1) begin : g_m
      always_ff @(posedge clk) begin
        if (en) begin
          m[k+1] <= m[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl[N].czero) begin
        result <= 32'h0;
        ovf    <= 1'b0;
      end else if (fl[N].mzero) begin
        result <= fl[N].cneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        ovf    <= 1'b1;
      end else if (fl[N].neg) begin
        if (fl[N].big || (q[N-1] > 32'h8000_0000)) begin
          result <= 32'h8000_0000;
          ovf    <= 1'b1;
        end else begin
          result <= ~q[N-1] + 32'd1;
          ovf    <= 1'b0;
        end
      end else begin
        if (fl[N].big || q[N-1][31]) begin
          result <= 32'h7FFF_FFFF;
          ovf    <= 1'b1;
        end else begin
          result <= q[N-1];
          ovf    <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/radial_inverse_point_map.sv
// Maps one signed Q16.16 point per clock while the pipeline is not frozen:
// points closer to the origin than inner_radius pass unchanged, all others
// are scaled so that their new radius is 1/(coef_a*r - coef_b), saturating
// with overflow set. The depth comes from the 32-stage radius square root and
// the 32-stage quotient pipelines, one result bit per stage. Output stall
// freezes the whole pipeline while the output register and its skid register
// are both full. Write configuration only while idle.
module radial_inverse_point_map (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out,
  output logic               moved,
  output logic               overflow
);

  localparam int D  = rim_pkg::PIPE_DEPTH;
  localparam int SQ = rim_pkg::SQRT_STAGES;
  localparam int DV = rim_pkg::DIV_STAGES;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               moved;
    logic               ovf;
  } result_t;

  logic [31:0] inner_radius;
  logic [47:0] coef_a;
  logic [47:0] coef_b;
  logic        a_neg;
  logic [47:0] a_mag;

  logic         en;
  logic [D-1:0] vld;

  rim_pkg::point_t pt1, pt2, pt3, pt4, pt5, pt6, pt7, pt8, pt9;
  rim_pkg::point_t sq_pt [SQ];
  rim_pkg::point_t dv_pt [DV];
  logic            dv_moved [DV];

  logic [31:0] mx, my, mz;
  logic [63:0] sq_x, sq_y, sq_z;
  logic [63:0] sum;
  logic [31:0] root;
  logic [31:0] r3, r4, r5, r6, r7;
  logic        moved3, moved4, moved5, moved6, moved7, moved8, moved9;
  logic [47:0] ph3;
  logic [63:0] pl3;
  logic [63:0] t4;
  logic [63:0] st5;
  logic [64:0] diff;
  logic [63:0] d6;
  logic        dneg7, dneg8, dneg9;
  logic [63:0] dmag7;
  logic [63:0] pp0, pp1;
  logic [95:0] m9;
  logic [31:0] qx, qy, qz;
  logic        ox, oy, oz;

  result_t res, obuf, skid;
  logic    skid_valid;
  logic    take;
  logic    out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= '0;
      coef_a       <= '0;
      coef_b       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rim_pkg::CFG_INNER_RADIUS: inner_radius <= cfg_data[31:0];
        rim_pkg::CFG_COEF_A:       coef_a       <= cfg_data;
        rim_pkg::CFG_COEF_B:       coef_b       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_neg <= coef_a[47];
    a_mag <= coef_a[47] ? (~coef_a + 48'd1) : coef_a;
  end

  assign en       = ~skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], in_valid};
    end
  end

  assign mx = rim_pkg::mag32(x_in);
  assign my = rim_pkg::mag32(y_in);
  assign mz = rim_pkg::mag32(z_in);

  always_ff @(posedge clk) begin
    if (en) begin
      pt1  <= '{x: x_in, y: y_in, z: z_in};
      sq_x <= mx * mx;
      sq_y <= my * my;
      sq_z <= mz * mz;
      pt2  <= pt1;
      sum  <= sq_x + sq_y + sq_z;
    end
  end

  rim_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_pt[0] <= pt2;
      for (int k = 1; k < SQ; k++) begin
        sq_pt[k] <= sq_pt[k-1];
      end
    end
  end

  assign diff = {st5[63], st5} - {{17{coef_b[47]}}, coef_b};

  always_ff @(posedge clk) begin
    if (en) begin
      pt3    <= sq_pt[SQ-1];
      r3     <= root;
      moved3 <= (root >= inner_radius);
      ph3    <= a_mag[47:32] * root;
      pl3    <= a_mag[31:0] * root;

      pt4    <= pt3;
      r4     <= r3;
      moved4 <= moved3;
      t4     <= {ph3, 16'h0000} + {16'h0000, pl3[63:16]};

      pt5    <= pt4;
      r5     <= r4;
      moved5 <= moved4;
      st5    <= a_neg ? (~t4 + 64'd1) : t4;

      pt6    <= pt5;
      r6     <= r5;
      moved6 <= moved5;
      if (diff[64] != diff[63]) begin
        d6 <= diff[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        d6 <= diff[63:0];
      end

      pt7    <= pt6;
      r7     <= r6;
      moved7 <= moved6;
      dneg7  <= d6[63];
      dmag7  <= d6[63] ? (~d6 + 64'd1) : d6;

      pt8    <= pt7;
      moved8 <= moved7;
      dneg8  <= dneg7;
      pp0    <= dmag7[31:0] * r7;
      pp1    <= dmag7[63:32] * r7;

      pt9    <= pt8;
      moved9 <= moved8;
      dneg9  <= dneg8;
      m9     <= {32'h0, pp0} + {pp1, 32'h0};
    end
  end

  rim_div u_div_x (
    .clk     (clk),
    .en      (en),
    .divisor (m9),
    .coord   (pt9.x),
    .dneg    (dneg9),
    .result  (qx),
    .ovf     (ox)
  );

  rim_div u_div_y (
    .clk     (clk),
    .en      (en),
    .divisor (m9),
    .coord   (pt9.y),
    .dneg    (dneg9),
    .result  (qy),
    .ovf     (oy)
  );

  rim_div u_div_z (
    .clk     (clk),
    .en      (en),
    .divisor (m9),
    .coord   (pt9.z),
    .dneg    (dneg9),
    .result  (qz),
    .ovf     (oz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_pt[0]    <= pt9;
      dv_moved[0] <= moved9;
      for (int k = 1; k < DV; k++) begin
        dv_pt[k]    <= dv_pt[k-1];
        dv_moved[k] <= dv_moved[k-1];
      end
    end
  end

  always_comb begin
    if (dv_moved[DV-1]) begin
      res.x = qx;
      res.y = qy;
      res.z = qz;
    end else begin
      res.x = dv_pt[DV-1].x;
      res.y = dv_pt[DV-1].y;
      res.z = dv_pt[DV-1].z;
    end
    res.moved = dv_moved[DV-1];
    res.ovf   = dv_moved[DV-1] & (ox | oy | oz);
  end

  assign take     = vld[D-1] & en;
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid | take;
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      obuf <= skid_valid ? skid : res;
    end else if (take) begin
      skid <= res;
    end
  end

  assign x_out    = obuf.x;
  assign y_out    = obuf.y;
  assign z_out    = obuf.z;
  assign moved    = obuf.moved;
  assign overflow = obuf.ovf;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a transaction while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall && vld[D-1]))
    else $error("skid filled without a held output and a finished transaction");

  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && vld[D-1] |=> vld[D-1])
    else $error("pipeline tail dropped while frozen");

  a_unmoved_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !moved |-> !overflow)
    else $error("unmoved point flagged as overflow");

endmodule

>>> sim/point_map_checker.sv
`timescale 1ns / 100ps
module point_map_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] x_out,
  input  logic signed [31:0] y_out,
  input  logic signed [31:0] z_out,
  input  logic               moved,
  input  logic               overflow,
  output int                 fails,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        mv;
    logic        ov;
  } mapped_point_t;

  logic [31:0] inner_r;
  logic [47:0] coef_a;
  logic [47:0] coef_b;
  mapped_point_t mapped_q[$];

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] scale_coord(logic [31:0] c, logic dneg, logic [63:0] dmag,
                                              logic [63:0] r, inout logic ov);
    logic [32:0]  cmag;
    logic [127:0] den, num, q;
    cmag = c[31] ? (33'h1_0000_0000 - {1'b0, c}) : {1'b0, c};
    if (cmag == 0) return 32'd0;
    den = {64'd0, dmag} * {64'd0, r};
    if (den == 0) begin
      ov = 1'b1;
      return c[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    num = {95'd0, cmag} << 48;
    q = num / den;
    if (c[31] ^ dneg) begin
      if (q > 128'h8000_0000) begin
        ov = 1'b1;
        return 32'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic mapped_point_t map_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    mapped_point_t res;
    logic [63:0] sum, r, t, st, dmag, mx, my, mz;
    logic [48:0] amag, bmag;
    logic signed [65:0] bs, d;
    logic ov;
    mx = cx[31] ? 64'(-cx) : 64'(cx);
    my = cy[31] ? 64'(-cy) : 64'(cy);
    mz = cz[31] ? 64'(-cz) : 64'(cz);
    mx = {32'd0, mx[31:0]} | (cx == 32'h8000_0000 ? 64'h8000_0000 : 64'd0);
    my = {32'd0, my[31:0]} | (cy == 32'h8000_0000 ? 64'h8000_0000 : 64'd0);
    mz = {32'd0, mz[31:0]} | (cz == 32'h8000_0000 ? 64'h8000_0000 : 64'd0);
    sum = mx * mx + my * my + mz * mz;
    r = root64(sum);
    if (r < {32'd0, inner_r}) begin
      res = '{cx, cy, cz, 1'b0, 1'b0};
      return res;
    end
    amag = coef_a[47] ? (49'h1_0000_0000_0000 - {1'b0, coef_a}) : {1'b0, coef_a};
    bmag = coef_b[47] ? (49'h1_0000_0000_0000 - {1'b0, coef_b}) : {1'b0, coef_b};
    t = ((64'(amag >> 32) * r) << 16) + ((64'(amag[31:0]) * r) >> 16);
    st = coef_a[47] ? -t : t;
    bs = coef_b[47] ? -$signed({17'd0, bmag}) : $signed({17'd0, bmag});
    d = $signed({{2{st[63]}}, st}) - bs;
    if (d > $signed({2'b00, 64'h7FFF_FFFF_FFFF_FFFF})) d = {2'b00, 64'h7FFF_FFFF_FFFF_FFFF};
    if (d < $signed({2'b11, 64'h8000_0000_0000_0000})) d = {2'b11, 64'h8000_0000_0000_0000};
    dmag = d[63] ? -d[63:0] : d[63:0];
    ov = 1'b0;
    res.x = scale_coord(cx, d[63], dmag, r, ov);
    res.y = scale_coord(cy, d[63], dmag, r, ov);
    res.z = scale_coord(cz, d[63], dmag, r, ov);
    res.mv = 1'b1;
    res.ov = ov;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial fails = 0;
  assign pending = mapped_q.size();

  always @(posedge clk) begin
    mapped_point_t want;
    if (rst) begin
      inner_r <= 0;
      coef_a <= 0;
      coef_b <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (rim_pkg::cfg_index_t'(cfg_index))
          rim_pkg::CFG_INNER_RADIUS: inner_r <= cfg_data[31:0];
          rim_pkg::CFG_COEF_A:       coef_a <= cfg_data;
          rim_pkg::CFG_COEF_B:       coef_b <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) mapped_q.push_back(map_point(x_in, y_in, z_in));
      if (out_valid && !out_stall) begin
        if (mapped_q.size() == 0) begin
          report_mismatch("unexpected transaction", x_out, 32'd0);
        end else begin
          want = mapped_q.pop_front();
          if (x_out !== want.x) report_mismatch("x_out", x_out, want.x);
          if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
          if (z_out !== want.z) report_mismatch("z_out", z_out, want.z);
          if (moved !== want.mv) report_mismatch("moved", 32'(moved), 32'(want.mv));
          if (overflow !== want.ov) report_mismatch("overflow", 32'(overflow), 32'(want.ov));
        end
      end
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
module testbench;

  logic clk, rst;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] x_in, y_in, z_in, x_out, y_out, z_out;
  logic moved, overflow;
  int fails, pending;
  bit jitter, hold_req;

  radial_inverse_point_map uut (.*);
  point_map_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(rim_pkg::cfg_index_t idx, logic [47:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    if (jitter && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_in <= px;
    y_in <= py;
    z_in <= pz;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(32'h4_0000)) - 32'sh2_0000);
      default: return 32'($signed($urandom_range(32'h400_0000)) - 32'sh200_0000);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (rim_pkg::PIPE_DEPTH + 10) @(posedge clk);
  endtask

  always begin
    out_stall <= 1'b0;
    repeat ($urandom_range(10, 1)) @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (400) @(posedge clk);
      hold_req = 0;
    end else if (jitter && $urandom_range(1) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
  end

  logic [31:0] edge_vals[6] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'hFFFF_FFFF, 32'h0001_0000};
  logic [31:0] radius_set[6] = '{32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_8000,
                                 32'h0002_0000, 32'h0};
  logic [47:0] a_set[6] = '{48'h0, 48'h1_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                            48'hFFFF_0000_0000, 48'h0};
  logic [47:0] b_set[6] = '{48'h0, 48'h0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                            48'h0000_8000_0000, 48'h0};

  initial begin
    cfg_wr_en = 0;
    cfg_index = rim_pkg::CFG_INNER_RADIUS;
    cfg_data = 0;
    in_valid = 0;
    x_in = 0;
    y_in = 0;
    z_in = 0;
    jitter = 1;
    hold_req = 0;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (edge_vals[i]) begin
      send_point(edge_vals[i], edge_vals[(i + 2) % 6], edge_vals[(i + 4) % 6]);
    end
    drain();
    write_reg(rim_pkg::CFG_INNER_RADIUS, 48'h0002_0000);
    write_reg(rim_pkg::CFG_COEF_A, 48'h1_0000_0000);
    write_reg(rim_pkg::CFG_COEF_B, 48'h0);
    send_point(32'h0001_0000, 0, 0);
    send_point(32'hFFFF_0000, 32'h0000_8000, 0);
    send_point(32'h0002_0000, 0, 0);
    send_point(32'hFFFE_0000, 0, 0);
    send_point(32'h0000_0100, 32'h0000_0100, 32'h0000_0100);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    drain();
    write_reg(rim_pkg::CFG_INNER_RADIUS, 48'h0);
    send_point(0, 0, 0);
    send_point(32'h0000_0010, 0, 32'hFFFF_FFF0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(rim_pkg::CFG_INNER_RADIUS, {16'd0, radius_set[ph]});
      write_reg(rim_pkg::CFG_COEF_A, (ph == 5) ? 48'($urandom) << 8 : a_set[ph]);
      write_reg(rim_pkg::CFG_COEF_B, (ph == 5) ? 48'($urandom) : b_set[ph]);
      jitter = (ph != 5);
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 180; n++) begin
        int mode;
        mode = $urandom_range(2);
        send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode));
      end
      drain();
    end

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rim_pkg.sv
sv/rim_sqrt.sv
sv/rim_div.sv
sv/radial_inverse_point_map.sv
sim/point_map_checker.sv
sim/testbench.sv
